// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante, sampled on clock, quiet in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check cons in the same cycle as ante
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pncm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pncm_pkg;

   // Sizes fixed by the beat formats
   localparam int unsigned DEFAULT_MAX_ENTRIES = 256;
   localparam int unsigned COLOR_W  = 24;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned DIST_W   = 18;
   localparam int unsigned LENGTH_W = 9;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 9'd256;
   localparam logic [DIST_W-1:0]   MAX_DISTANCE = 18'd195075;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_MATCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [INDEX_W-1:0]   entry_index;
      logic [COLOR_W-1:0]   color;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]   best_index;
      logic [DIST_W-1:0]    best_distance;
   } rsp_type;

   // Control carried alongside a palette read through the pipeline
   typedef struct packed {
      logic                 vld;
      logic                 last;
      logic [INDEX_W-1:0]   idx;
   } pipe_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/pncm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pncm_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pncm_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pncm_dist
   import pncm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pipe_ctl_type       ctl,
   input  wire logic [COLOR_W-1:0] entry_color,
   input  wire logic [COLOR_W-1:0] query_color,
   output      pipe_ctl_type       dist_ctl,
   output      logic [DIST_W-1:0]  distance
);

   pipe_ctl_type      ctl_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;
   logic [15:0]       sq_red;
   logic [15:0]       sq_green;
   logic [15:0]       sq_blue;

   function automatic logic [15:0] channel_sq(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   // Square each channel difference and sum
   always_comb begin
      sq_red   = channel_sq(entry_color[23:16], query_color[23:16]);
      sq_green = channel_sq(entry_color[15:8],  query_color[15:8]);
      sq_blue  = channel_sq(entry_color[7:0],   query_color[7:0]);
      dist_in  = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
   end

   // Advance the control beside the distance
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_ctl = ctl_ff;
   assign distance = dist_ff;

endmodule

`default_nettype wire

// ===== rtl/core/palette_nearest_color_match.sv =====
// Palette nearest-color match, squared RGB distance.
// Write beat: taken while idle, stored the same edge, no response.
// Match beat: scans the n active entries (n = active palette length) from the top down;
//   one palette read per cycle, then drain and done; no new beat is taken until the response loads.
// A finished match waits in the done state while the previous response is still stalled.
// Reset (synchronous): control cleared, palette_length set to 256, palette contents undefined.
`timescale 1ns / 1ps
`default_nettype none

module palette_nearest_color_match
   import pncm_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire req_type             req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      rsp_type             rsp_data,
   input  wire logic                csr_write_enable,
   input  wire logic [LENGTH_W-1:0] csr_write_data
);

   localparam int unsigned AW          = $clog2(MAX_ENTRIES);
   localparam int unsigned ADDRESSABLE = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
   localparam int unsigned SW          = $clog2(ADDRESSABLE);
   localparam logic [LENGTH_W-1:0] ADDR_LIMIT = LENGTH_W'(ADDRESSABLE);

   state_type           state_ff, state_in;
   logic [LENGTH_W-1:0] palette_length_ff;
   logic [SW-1:0]       addr_ff, addr_in;
   logic [COLOR_W-1:0]  query_ff;
   logic                first_ff, first_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic [INDEX_W-1:0]  best_idx_ff, best_idx_in;
   pipe_ctl_type        rd_ctl_ff, rd_ctl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic                req_take;
   logic                match_start;
   logic                write_hit;
   logic                rd_en;
   logic                rsp_load;
   logic [LENGTH_W-1:0] active_len;
   logic [COLOR_W-1:0]  rd_color;
   pipe_ctl_type        dist_ctl;
   logic [DIST_W-1:0]   distance;
   logic                take_best;

   // Accepted beats; writes outside the store are dropped
   assign req_take    = req_valid && !req_stall;
   assign match_start = req_take && (req_data.operation == OP_MATCH);
   assign write_hit   = req_take && (req_data.operation == OP_WRITE)
                        && (32'(req_data.entry_index) < 32'(MAX_ENTRIES));

   // Clamp the configured length to 1 .. addressable entries
   always_comb begin
      active_len = palette_length_ff;
      if (active_len == '0) begin
         active_len = LENGTH_W'(1);
      end
      if (active_len > ADDR_LIMIT) begin
         active_len = ADDR_LIMIT;
      end
   end

   // Length register
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_length_ff <= LENGTH_RESET;
      end else if (csr_write_enable) begin
         palette_length_ff <= csr_write_data;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (match_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_ctl.vld && dist_ctl.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SCAN:  rd_en     = 1'b1;
         ST_DRAIN: rd_en     = 1'b0;
         ST_DONE:  rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan address: start at the top entry, count down
   always_comb begin
      addr_in = addr_ff;
      if (match_start) begin
         addr_in = SW'(active_len - LENGTH_W'(1));
      end else if (rd_en && (addr_ff != '0)) begin
         addr_in = addr_ff - SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (match_start) begin
         query_ff <= req_data.color;
      end
   end

   // Tag each read with its index and the last-entry mark
   always_comb begin
      rd_ctl_in      = '0;
      rd_ctl_in.vld  = rd_en;
      rd_ctl_in.last = rd_en && (addr_ff == '0);
      rd_ctl_in.idx  = INDEX_W'(addr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff <= '0;
      end else begin
         rd_ctl_ff <= rd_ctl_in;
      end
   end

   // Palette store; writes only land while idle, so no read overlaps a write
   pncm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (write_hit),
      .wr_addr (AW'(req_data.entry_index)),
      .wr_data (req_data.color),
      .rd_en   (rd_en),
      .rd_addr (AW'(addr_ff)),
      .rd_data (rd_color)
   );

   pncm_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .ctl         (rd_ctl_ff),
      .entry_color (rd_color),
      .query_color (query_ff),
      .dist_ctl    (dist_ctl),
      .distance    (distance)
   );

   // Keep the best so far; strict compare keeps the higher index on a tie
   assign take_best = dist_ctl.vld && (first_ff || (distance < best_dist_ff));

   always_comb begin
      first_in     = first_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (match_start) begin
         first_in = 1'b1;
      end else if (take_best) begin
         first_in     = 1'b0;
         best_dist_in = distance;
         best_idx_in  = dist_ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   // Response register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.best_index    <= best_idx_ff;
         rsp_data_ff.best_distance <= best_dist_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pncm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pncm_checker
   import pncm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic match_beat;
   logic write_beat;

   assign match_beat = req_valid && !req_stall && (req_data.operation == OP_MATCH);
   assign write_beat = req_valid && !req_stall && (req_data.operation == OP_WRITE);

   // Hold a stalled response
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed under stall")

   // Busy right after a match beat
   `ASSERT_NEXT(a_match_busy, match_beat, req_stall, "request taken during a scan")

   // A write beat makes no response
   `ASSERT_NEXT(a_write_quiet, write_beat && !rsp_valid, !rsp_valid, "response after a write beat")

   // Distance never exceeds three full-scale squares
   `ASSERT_SAME(a_dist_range, rsp_valid, rsp_data.best_distance <= MAX_DISTANCE, "distance out of range")

endmodule

bind palette_nearest_color_match pncm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/palette_nearest_color_match_tb.sv =====
`timescale 1ns / 1ps

module palette_nearest_color_match_tb;
   import pncm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PHASE_BEATS = 28;
   localparam int unsigned HOLD_OFF_CYCLES = 1200;

   // Palette mirror and the queue of best matches still owed by the block
   class nearest_match_tracker;
      logic [COLOR_W-1:0]  palette [DEFAULT_MAX_ENTRIES];
      logic [LENGTH_W-1:0] length_setting;
      rsp_type             expected_matches [$];
      int unsigned         failures;

      function new();
         foreach (palette[i]) palette[i] = '0;
         length_setting = LENGTH_RESET;
         failures = 0;
      endfunction

      // Zero acts as one; anything past the store saturates
      function int unsigned active_length();
         int unsigned n;
         n = 32'(length_setting);
         if (n < 1) n = 1;
         if (n > DEFAULT_MAX_ENTRIES) n = DEFAULT_MAX_ENTRIES;
         return n;
      endfunction

      // Scan from the top entry down; strict compare keeps the highest index on a tie
      function rsp_type nearest_entry(logic [COLOR_W-1:0] query);
         rsp_type     best;
         int unsigned total;
         int          gap;
         bit          found;
         found = 1'b0;
         best = '0;
         for (int i = int'(active_length()) - 1; i >= 0; i--) begin
            total = 0;
            for (int ch = 0; ch < 3; ch++) begin
               gap = int'(palette[i][ch*8 +: 8]) - int'(query[ch*8 +: 8]);
               total += 32'(gap * gap);
            end
            if (!found || total < 32'(best.best_distance)) begin
               found = 1'b1;
               best.best_index = i[INDEX_W-1:0];
               best.best_distance = total[DIST_W-1:0];
            end
         end
         return best;
      endfunction

      function void note_request(req_type beat);
         if (beat.operation == OP_WRITE) begin
            palette[beat.entry_index] = beat.color;
         end else begin
            expected_matches.push_back(nearest_entry(beat.color));
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_matches.size() == 0) begin
            $error("unexpected result beat: best_index %0d best_distance %0d",
                   got.best_index, got.best_distance);
            failures++;
            return;
         end
         want = expected_matches.pop_front();
         if (got.best_index !== want.best_index) begin
            $error("best_index mismatch: expected %0d, actual %0d",
                   want.best_index, got.best_index);
            failures++;
         end
         if (got.best_distance !== want.best_distance) begin
            $error("best_distance mismatch: expected %0d, actual %0d",
                   want.best_distance, got.best_distance);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_matches.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_write_enable;
   logic [LENGTH_W-1:0] csr_write_data;

   nearest_match_tracker tracker = new();
   int unsigned          cycle_count = 0;
   int unsigned          quiet_left = 0;
   bit                   hold_off_request = 1'b0;

   palette_nearest_color_match dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check every result beat taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_response(rsp_data);
      end
   end

   // Receiver stall: runs of open and stalled cycles, plus one long hold-off on request
   initial begin
      int unsigned run_left;
      int unsigned hold_left;
      bit          hold_taken;
      bit          stall_value;
      bit          next_stall;
      int          r;
      run_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      stall_value = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 15) begin
                  stall_value = 1'b0;
                  run_left = $urandom_range(40, 150);
               end else if (r < 60) begin
                  stall_value = 1'b0;
                  run_left = $urandom_range(1, 8);
               end else if (r < 92) begin
                  stall_value = 1'b1;
                  run_left = $urandom_range(1, 3);
               end else begin
                  stall_value = 1'b1;
                  run_left = $urandom_range(15, 60);
               end
            end
            run_left--;
            next_stall = stall_value;
         end
         rsp_stall <= next_stall;
      end
   end

   // Idle cycles before the next input beat: mostly none, some short, a few long
   function automatic int unsigned sender_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Offer one beat and hold it until the block takes it
   task automatic send_beat(req_type beat);
      int unsigned gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      tracker.note_request(beat);
   endtask

   task automatic write_entry(logic [INDEX_W-1:0] index, logic [COLOR_W-1:0] hue);
      req_type beat;
      beat.operation = OP_WRITE;
      beat.entry_index = index;
      beat.color = hue;
      send_beat(beat);
   endtask

   // The index field is don't-care on a match, so fill it with noise
   task automatic match_color(logic [COLOR_W-1:0] hue);
      req_type beat;
      beat.operation = OP_MATCH;
      beat.entry_index = INDEX_W'($urandom_range(0, 255));
      beat.color = hue;
      send_beat(beat);
   endtask

   // Drop valid, wait out every owed result, then let the block go idle
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_length(logic [LENGTH_W-1:0] value);
      settle_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.length_setting = value;
   endtask

   initial begin
      int unsigned        lengths [10];
      int unsigned        n;
      int                 r;
      logic [INDEX_W-1:0] pick;
      logic [COLOR_W-1:0] hue;
      lengths = '{3, 256, 2, 16, 511, 1, 7, 256, 40, 5};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single entry: opposite colors must still match at full distance
      write_length(9'd1);
      write_entry(8'd0, 24'h000000);
      match_color(24'hFFFFFF);
      write_entry(8'd0, 24'hFFFFFF);
      match_color(24'h000000);
      match_color(24'hFFFFFF);

      // Length zero behaves as one
      write_length(9'd0);
      match_color(24'h123456);

      // Four entries with a duplicated color to exercise the tie rule
      write_length(9'd4);
      write_entry(8'd1, 24'h808080);
      write_entry(8'd2, 24'hFF0000);
      write_entry(8'd3, 24'h808080);
      match_color(24'h808080);
      match_color(24'hFF0000);
      match_color(24'h00FF00);
      match_color(24'h0000FF);

      // Fill the whole store, then run with an oversized length and the full one
      for (int i = 4; i < 256; i++) write_entry(i[INDEX_W-1:0], COLOR_W'($urandom));
      write_length(9'h1FF);
      match_color(24'h000000);
      match_color(24'hFFFFFF);
      write_length(9'd256);
      match_color(24'h7F7F7F);

      // Random phases; the first one runs against the long receiver hold-off
      foreach (lengths[p]) begin
         write_length(LENGTH_W'(lengths[p]));
         if (p == 0) hold_off_request = 1'b1;
         n = tracker.active_length();
         repeat (PHASE_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               pick = (r < 13) ? INDEX_W'($urandom_range(0, n - 1))
                               : INDEX_W'($urandom_range(0, 255));
               hue = ($urandom_range(0, 2) == 0) ? tracker.palette[$urandom_range(0, n - 1)]
                                                 : COLOR_W'($urandom);
               write_entry(pick, hue);
            end else begin
               r = $urandom_range(0, 99);
               pick = INDEX_W'($urandom_range(0, n - 1));
               if (r < 40) begin
                  hue = COLOR_W'($urandom);
               end else if (r < 65) begin
                  hue = tracker.palette[pick];
               end else if (r < 80) begin
                  hue = tracker.palette[pick] ^ (COLOR_W'($urandom) & 24'h070707);
               end else begin
                  case ($urandom_range(0, 4))
                     0: hue = 24'h000000;
                     1: hue = 24'hFFFFFF;
                     2: hue = 24'hFF0000;
                     3: hue = 24'h00FF00;
                     default: hue = 24'h0000FF;
                  endcase
               end
               match_color(hue);
            end
         end
      end

      // Drain, allow one full scan of slack, then report
      settle_idle();
      repeat (300) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
